/* src/can_id_mailbox_table_assert.svh */
// Assertion macros shared by the checks of the mailbox table checker.
`ifndef CAN_ID_MAILBOX_TABLE_ASSERT_SVH
`define CAN_ID_MAILBOX_TABLE_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define CMT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mailbox table check failed");

// Next-cycle implication, off while reset is high.
`define CMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mailbox table check failed");

// Condition that must hold in the cycle after reset.
`define CMT_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("mailbox table reset check failed");

`endif

/* src/cmt_pkg.sv */
// Package with types and constants of the CAN identifier mailbox table.
`timescale 1ns / 1ps
package cmt_pkg;

   localparam int CMT_TABLE_ENTRIES = 64;
   localparam int CMT_QUEUE_DEPTH   = 2;

   localparam int MODE_W  = 2;
   localparam int INDEX_W = 6;
   localparam int ID_W    = 29;
   localparam int DATA_W  = 64;
   localparam int SEC_W   = 6;

   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FRAME = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_FRAME,
      OP_READ,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_COPY,
      ST_READ_OUT
   } state_type;

   typedef struct packed {
      op_type               op;
      logic [INDEX_W-1:0]   entry;
      logic [ID_W-1:0]      id;
      logic [DATA_W-1:0]    data;
      logic [SEC_W-1:0]     sec;
   } cmd_type;

   typedef struct packed {
      logic                 match_found;
      logic                 snapshot_taken;
      logic [ID_W-1:0]      read_id;
      logic [DATA_W-1:0]    read_data;
   } rsp_type;

endpackage

/* src/cmt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/cmt_fifo.sv */
// Small register queue used between front and back and on the result side.
`timescale 1ns / 1ps
module cmt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/cmt_front.sv */
// Front end: accepts requests, decodes the mode and queues commands.
`timescale 1ns / 1ps
module cmt_front
   import cmt_pkg::*;
#(
   parameter int TABLE_ENTRIES = CMT_TABLE_ENTRIES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [INDEX_W-1:0] req_entry_index,
   input  logic [ID_W-1:0]    req_can_id,
   input  logic [DATA_W-1:0]  req_frame_data,
   input  logic [SEC_W-1:0]   req_rtc_seconds,
   input  logic               cmd_pop,
   output logic               cmd_valid,
   output cmd_type            cmd
);

   cmd_type                  cmd_push;
   logic                     in_range;
   logic                     cmd_empty;
   logic [$bits(cmd_type)-1:0] cmd_bits;

   assign in_range = (int'(req_entry_index) < TABLE_ENTRIES);

   always_comb begin
      cmd_push.entry = req_entry_index;
      cmd_push.id    = req_can_id;
      cmd_push.data  = req_frame_data;
      cmd_push.sec   = req_rtc_seconds;
      case (req_mode)
         MODE_LOAD:  cmd_push.op = in_range ? OP_LOAD : OP_NONE;
         MODE_FRAME: cmd_push.op = OP_FRAME;
         MODE_READ:  cmd_push.op = in_range ? OP_READ : OP_NONE;
         default:    cmd_push.op = OP_NONE;
      endcase
   end

   cmt_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMT_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cmd_push),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_bits),
      .empty     (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;
   assign cmd       = cmd_type'(cmd_bits);

endmodule

/* src/cmt_back.sv */
// Back end: runs commands against the identifier, working and snapshot stores.
`timescale 1ns / 1ps
module cmt_back
   import cmt_pkg::*;
#(
   parameter int TABLE_ENTRIES = CMT_TABLE_ENTRIES,
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp
);

   state_type                state_ff, state_in;
   cmd_type                  cur_ff, cur_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     pend_ff, pend_in;
   logic [IDX_W-1:0]         pend_addr_ff, pend_addr_in;
   logic                     match_ff, match_in;
   logic                     snap_ff, snap_in;
   logic [SEC_W-1:0]         last_sec_ff, last_sec_in;
   logic [TABLE_ENTRIES-1:0] id_valid_ff, id_valid_in;
   logic [TABLE_ENTRIES-1:0] wk_valid_ff, wk_valid_in;
   logic [TABLE_ENTRIES-1:0] sn_valid_ff, sn_valid_in;
   logic                     id_vq_ff, id_vq_in;
   logic                     wk_vq_ff, wk_vq_in;
   logic                     sn_vq_ff, sn_vq_in;

   logic                     id_we, wk_we, sn_we;
   logic [IDX_W-1:0]         id_waddr, wk_waddr, sn_waddr;
   logic [ID_W-1:0]          id_wdata;
   logic [DATA_W-1:0]        wk_wdata, sn_wdata;
   logic [IDX_W-1:0]         id_raddr, wk_raddr, sn_raddr;
   logic [ID_W-1:0]          id_q, id_seen;
   logic [DATA_W-1:0]        wk_q, sn_q;
   logic [IDX_W-1:0]         cur_addr, cnt_addr;
   logic                     cnt_done;

   assign cur_addr = IDX_W'(cur_ff.entry);
   assign cnt_addr = cnt_ff[IDX_W-1:0];
   assign cnt_done = (cnt_ff == CNT_W'(TABLE_ENTRIES));
   assign id_seen  = id_vq_ff ? id_q : '0;

   assign id_raddr = (state_ff == ST_SCAN) ? cnt_addr : cur_addr;
   assign wk_raddr = cnt_addr;
   assign sn_raddr = cur_addr;
   assign id_vq_in = id_valid_ff[id_raddr];
   assign wk_vq_in = wk_valid_ff[wk_raddr];
   assign sn_vq_in = sn_valid_ff[sn_raddr];

   cmt_ram #(.WIDTH(ID_W), .DEPTH(TABLE_ENTRIES)) u_id_ram (
      .clock   (clock),
      .wr_en   (id_we),
      .wr_addr (id_waddr),
      .wr_data (id_wdata),
      .rd_addr (id_raddr),
      .rd_data (id_q)
   );

   cmt_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_ENTRIES)) u_work_ram (
      .clock   (clock),
      .wr_en   (wk_we),
      .wr_addr (wk_waddr),
      .wr_data (wk_wdata),
      .rd_addr (wk_raddr),
      .rd_data (wk_q)
   );

   cmt_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_ENTRIES)) u_snap_ram (
      .clock   (clock),
      .wr_en   (sn_we),
      .wr_addr (sn_waddr),
      .wr_data (sn_wdata),
      .rd_addr (sn_raddr),
      .rd_data (sn_q)
   );

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      match_in     = match_ff;
      snap_in      = snap_ff;
      last_sec_in  = last_sec_ff;
      id_valid_in  = id_valid_ff;
      wk_valid_in  = wk_valid_ff;
      sn_valid_in  = sn_valid_ff;
      id_we        = 1'b0;
      id_waddr     = cur_addr;
      id_wdata     = cur_ff.id;
      wk_we        = 1'b0;
      wk_waddr     = pend_addr_ff;
      wk_wdata     = cur_ff.data;
      sn_we        = 1'b0;
      sn_waddr     = pend_addr_ff;
      sn_wdata     = wk_vq_ff ? wk_q : '0;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      rsp          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop  = 1'b1;
               cur_in   = cmd;
               match_in = 1'b0;
               snap_in  = 1'b0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cur_ff.op)
               OP_LOAD: begin
                  id_we                 = 1'b1;
                  id_valid_in[cur_addr] = 1'b1;
                  wk_valid_in[cur_addr] = 1'b0;
                  rsp_push              = 1'b1;
                  state_in              = ST_IDLE;
               end
               OP_FRAME: begin
                  cnt_in   = '0;
                  state_in = ST_SCAN;
               end
               OP_READ: begin
                  state_in = ST_READ_OUT;
               end
               default: begin
                  rsp_push = 1'b1;
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SCAN: begin
            if (!cnt_done) begin
               pend_in      = 1'b1;
               pend_addr_in = cnt_addr;
               cnt_in       = cnt_ff + 1'b1;
            end
            if (pend_ff && (id_seen == cur_ff.id)) begin
               wk_we                     = 1'b1;
               wk_valid_in[pend_addr_ff] = 1'b1;
               match_in                  = 1'b1;
            end
            if (cnt_done && !pend_ff) begin
               if (cur_ff.sec != last_sec_ff) begin
                  last_sec_in = cur_ff.sec;
                  snap_in     = 1'b1;
                  cnt_in      = '0;
                  state_in    = ST_COPY;
               end else begin
                  rsp_push        = 1'b1;
                  rsp.match_found = match_ff;
                  state_in        = ST_IDLE;
               end
            end
         end
         ST_COPY: begin
            if (!cnt_done) begin
               pend_in      = 1'b1;
               pend_addr_in = cnt_addr;
               cnt_in       = cnt_ff + 1'b1;
            end
            if (pend_ff) begin
               sn_we                     = 1'b1;
               sn_valid_in[pend_addr_ff] = 1'b1;
            end
            if (cnt_done && !pend_ff) begin
               rsp_push           = 1'b1;
               rsp.match_found    = match_ff;
               rsp.snapshot_taken = snap_ff;
               state_in           = ST_IDLE;
            end
         end
         ST_READ_OUT: begin
            rsp_push      = 1'b1;
            rsp.read_id   = id_seen;
            rsp.read_data = sn_vq_ff ? sn_q : '0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         pend_ff     <= 1'b0;
         match_ff    <= 1'b0;
         snap_ff     <= 1'b0;
         last_sec_ff <= '0;
         id_valid_ff <= '0;
         wk_valid_ff <= '0;
         sn_valid_ff <= '0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         pend_ff     <= pend_in;
         match_ff    <= match_in;
         snap_ff     <= snap_in;
         last_sec_ff <= last_sec_in;
         id_valid_ff <= id_valid_in;
         wk_valid_ff <= wk_valid_in;
         sn_valid_ff <= sn_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      pend_addr_ff <= pend_addr_in;
      id_vq_ff     <= id_vq_in;
      wk_vq_ff     <= wk_vq_in;
      sn_vq_ff     <= sn_vq_in;
   end

endmodule

/* src/can_id_mailbox_table.sv */
// Top level of the CAN identifier mailbox table.
// The back end takes one request at a time and answers it before taking the next: a load or an
// unused mode answers from the execute state, a read answers from the stored identifier and
// snapshot data, a frame runs a scan pass over every entry, and a frame whose seconds value
// differs from the last one recorded then runs a copy pass from the working to the snapshot store.
// Reset: synchronous; per-entry valid bits make unwritten entries read as zero.
`timescale 1ns / 1ps
module can_id_mailbox_table
   import cmt_pkg::*;
#(
   parameter int TABLE_ENTRIES = CMT_TABLE_ENTRIES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [INDEX_W-1:0] req_entry_index,
   input  logic [ID_W-1:0]    req_can_id,
   input  logic [DATA_W-1:0]  req_frame_data,
   input  logic [SEC_W-1:0]   req_rtc_seconds,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               rsp_match_found,
   output logic               rsp_snapshot_taken,
   output logic [ID_W-1:0]    rsp_read_id,
   output logic [DATA_W-1:0]  rsp_read_data
);

   cmd_type                    cmd;
   logic                       cmd_valid;
   logic                       cmd_pop;
   logic                       result_full;
   logic                       result_push;
   rsp_type                    result;
   logic [$bits(rsp_type)-1:0] result_bits;
   rsp_type                    head;

   cmt_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_mode        (req_mode),
      .req_entry_index (req_entry_index),
      .req_can_id      (req_can_id),
      .req_frame_data  (req_frame_data),
      .req_rtc_seconds (req_rtc_seconds),
      .cmd_pop         (cmd_pop),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd)
   );

   cmt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (result_full),
      .rsp_push  (result_push),
      .rsp       (result)
   );

   cmt_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (CMT_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result),
      .full      (result_full),
      .pop       (rsp_pop),
      .pop_data  (result_bits),
      .empty     (rsp_empty)
   );

   assign head               = rsp_type'(result_bits);
   assign rsp_match_found    = head.match_found;
   assign rsp_snapshot_taken = head.snapshot_taken;
   assign rsp_read_id        = head.read_id;
   assign rsp_read_data      = head.read_data;

endmodule

/* src/cmt_checker.sv */
// Port-level checker for the mailbox table, bound to the top level.
`timescale 1ns / 1ps
`include "can_id_mailbox_table_assert.svh"
module cmt_checker
   import cmt_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic               rsp_match_found,
   input logic               rsp_snapshot_taken,
   input logic [ID_W-1:0]    rsp_read_id,
   input logic [DATA_W-1:0]  rsp_read_data
);

   logic read_zero;

   assign read_zero = (rsp_read_id == '0) && (rsp_read_data == '0);

   `CMT_ASSERT_AFTER_RESET(a_reset_drains, clock, reset, rsp_empty && !req_full)
   `CMT_ASSERT_NEXT(a_result_held, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty)
   `CMT_ASSERT_IMPLY(a_read_excl_match, clock, reset, !rsp_empty && rsp_match_found, read_zero)
   `CMT_ASSERT_IMPLY(a_read_excl_snap, clock, reset, !rsp_empty && rsp_snapshot_taken, read_zero)

endmodule

bind can_id_mailbox_table cmt_checker u_cmt_checker (.*);
